// ===== hw/rtl/ngga_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared types, constants and helper functions for the GGA position parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned LAT_DEG_W = 7;
    localparam int unsigned LON_DEG_W = 10;
    localparam int unsigned MIN_W     = 20;
    localparam int unsigned LAT_W     = 27;
    localparam int unsigned LON_W     = 30;
    localparam int unsigned DIGIT_W   = 4;

    // Sentence layout
    localparam logic [POS_W-1:0] PREFIX_LEN     = 6'd7;
    localparam logic [POS_W-1:0] PREFIX_LAST    = 6'd6;
    localparam logic [POS_W-1:0] LAST_DIGIT_POS = 6'd40;
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;

    // ASCII digit range
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // Scaling: degrees to microdegrees, and floor(M*5/3) as (M*MIN_RECIP) >> MIN_SHIFT.
    // MIN_RECIP = 5 * ceil(2^24 / 3); exact for 5*M below 2^23.
    localparam int unsigned MICRO_W   = 20;
    localparam logic [MICRO_W-1:0] MICRO = 20'd1000000;
    localparam int unsigned RECIP_W   = 25;
    localparam logic [RECIP_W-1:0] MIN_RECIP = 25'd27962030;
    localparam int unsigned MIN_SHIFT = 24;
    localparam int unsigned PROD_W    = MIN_W + RECIP_W;
    localparam int unsigned FRAC_W    = 21;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PREFIX = 2'd1,
        ST_DIGIT  = 2'd2
    } t_status;

    // What a byte position carries
    typedef enum logic [2:0] {
        DK_NONE,
        DK_LAT_DEG,
        DK_LAT_MIN,
        DK_LON_DEG,
        DK_LON_MIN
    } t_digit_kind;

    // Snapshot of one finished sentence, handed from scanner to converter
    typedef struct packed {
        t_status              status;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
    } t_fix;

    // Expected "$GNGGA," character at a prefix position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h24;
                3'd1:    c = 8'h47;
                3'd2:    c = 8'h4E;
                3'd3:    c = 8'h47;
                3'd4:    c = 8'h47;
                3'd5:    c = 8'h41;
                3'd6:    c = 8'h2C;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Field carried at a byte position
    function automatic t_digit_kind digit_kind(input logic [POS_W-1:0] p);
        t_digit_kind k;
        begin
            if (p == 6'd18 || p == 6'd19) begin
                k = DK_LAT_DEG;
            end else if (p == 6'd20 || p == 6'd21 || (p >= 6'd23 && p <= 6'd26)) begin
                k = DK_LAT_MIN;
            end else if (p >= 6'd31 && p <= 6'd33) begin
                k = DK_LON_DEG;
            end else if (p == 6'd34 || p == 6'd35 || (p >= 6'd37 && p <= 6'd40)) begin
                k = DK_LON_MIN;
            end else begin
                k = DK_NONE;
            end
            return k;
        end
    endfunction

endpackage : ngga_pkg
`default_nettype wire

// ===== hw/rtl/ngga_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ngga_scan
// Input register and per-byte sentence scanner: prefix check, digit
// accumulation and status; emits one snapshot per final byte.
// ----------------------------------------------------------------------------
module ngga_scan (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_byte_valid,
    output logic                             o_byte_ready,
    input  wire  [ngga_pkg::BYTE_W-1:0]      i_byte,
    input  wire                              i_byte_last,
    output logic                             o_fix_valid,
    input  wire                              i_fix_ready,
    output ngga_pkg::t_fix                   o_fix
);
    import ngga_pkg::*;

    // Input register
    logic                    r_in_valid;
    logic [BYTE_W-1:0]       r_in_byte;
    logic                    r_in_last;

    // Sentence state
    logic [POS_W-1:0]        r_pos,     n_pos;
    logic                    r_prefix,  n_prefix;
    logic                    r_digits,  n_digits;
    logic [LAT_DEG_W-1:0]    r_lat_deg, n_lat_deg;
    logic [MIN_W-1:0]        r_lat_min, n_lat_min;
    logic [LON_DEG_W-1:0]    r_lon_deg, n_lon_deg;
    logic [MIN_W-1:0]        r_lon_min, n_lon_min;

    // Snapshot register
    logic                    r_fix_valid;
    t_fix                    r_fix;
    t_fix                    n_fix;

    logic                    snap_ready;
    logic                    consume;
    logic                    is_digit;
    logic [DIGIT_W-1:0]      digit;
    t_digit_kind             kind;

    assign snap_ready   = !r_fix_valid || i_fix_ready;
    assign consume      = r_in_valid && (!r_in_last || snap_ready);
    assign o_byte_ready = !r_in_valid || consume;
    assign o_fix_valid  = r_fix_valid;
    assign o_fix        = r_fix;

    // Per-byte state update
    always_comb begin
        is_digit  = (r_in_byte >= ASCII_ZERO) && (r_in_byte <= ASCII_NINE);
        digit     = r_in_byte[DIGIT_W-1:0];
        kind      = digit_kind(r_pos);
        n_pos     = (r_pos == POS_MAX) ? r_pos : r_pos + 6'd1;
        n_prefix  = r_prefix;
        n_digits  = r_digits;
        n_lat_deg = r_lat_deg;
        n_lat_min = r_lat_min;
        n_lon_deg = r_lon_deg;
        n_lon_min = r_lon_min;

        if (r_pos < PREFIX_LEN && r_in_byte != prefix_char(r_pos[2:0])) begin
            n_prefix = 1'b0;
        end

        if (kind != DK_NONE && !is_digit) begin
            n_digits = 1'b0;
        end else if (is_digit) begin
            unique case (kind)
                DK_LAT_DEG: n_lat_deg = LAT_DEG_W'(r_lat_deg * 7'd10 + LAT_DEG_W'(digit));
                DK_LAT_MIN: n_lat_min = MIN_W'(r_lat_min * 20'd10 + MIN_W'(digit));
                DK_LON_DEG: n_lon_deg = LON_DEG_W'(r_lon_deg * 10'd10 + LON_DEG_W'(digit));
                DK_LON_MIN: n_lon_min = MIN_W'(r_lon_min * 20'd10 + MIN_W'(digit));
                default: ;
            endcase
        end
    end

    // Status and snapshot of the finished sentence
    always_comb begin
        n_fix = '0;
        if (!n_prefix || r_pos < PREFIX_LAST) begin
            n_fix.status = ST_PREFIX;
        end else if (!n_digits || r_pos < LAST_DIGIT_POS) begin
            n_fix.status = ST_DIGIT;
        end else begin
            n_fix.status  = ST_OK;
            n_fix.lat_deg = n_lat_deg;
            n_fix.lat_min = n_lat_min;
            n_fix.lon_deg = n_lon_deg;
            n_fix.lon_min = n_lon_min;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_byte_ready) begin
            r_in_valid <= i_byte_valid;
        end
        if (o_byte_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_byte_last;
        end
    end

    // Sentence state, cleared after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in_last)) begin
            r_pos     <= '0;
            r_prefix  <= 1'b1;
            r_digits  <= 1'b1;
            r_lat_deg <= '0;
            r_lat_min <= '0;
            r_lon_deg <= '0;
            r_lon_min <= '0;
        end else if (consume) begin
            r_pos     <= n_pos;
            r_prefix  <= n_prefix;
            r_digits  <= n_digits;
            r_lat_deg <= n_lat_deg;
            r_lat_min <= n_lat_min;
            r_lon_deg <= n_lon_deg;
            r_lon_min <= n_lon_min;
        end
    end

    // Snapshot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_valid <= 1'b0;
        end else if (snap_ready) begin
            r_fix_valid <= consume && r_in_last;
        end
        if (snap_ready && consume && r_in_last) begin
            r_fix <= n_fix;
        end
    end

endmodule : ngga_scan
`default_nettype wire

// ===== hw/rtl/ngga_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ngga_conv
// Converts degrees and minute digits to microdegrees in two registered
// steps: constant multiplies, then the final add into the result register.
// ----------------------------------------------------------------------------
module ngga_conv (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_fix_valid,
    output logic                             o_fix_ready,
    input  ngga_pkg::t_fix                   i_fix,
    output logic                             o_res_valid,
    input  wire                              i_res_ready,
    output ngga_pkg::t_status                o_status,
    output logic [ngga_pkg::LAT_W-1:0]       o_lat,
    output logic [ngga_pkg::LON_W-1:0]       o_lon
);
    import ngga_pkg::*;

    // Multiply stage
    logic                 r_m_valid;
    t_status              r_m_status;
    logic [LAT_W-1:0]     r_m_lat_whole;
    logic [FRAC_W-1:0]    r_m_lat_frac;
    logic [LON_W-1:0]     r_m_lon_whole;
    logic [FRAC_W-1:0]    r_m_lon_frac;

    // Result stage
    logic                 r_o_valid;
    t_status              r_o_status;
    logic [LAT_W-1:0]     r_o_lat;
    logic [LON_W-1:0]     r_o_lon;

    logic                 o_ready;
    logic                 m_ready;
    logic [PROD_W-1:0]    lat_prod;
    logic [PROD_W-1:0]    lon_prod;

    assign o_ready     = !r_o_valid || i_res_ready;
    assign m_ready     = !r_m_valid || o_ready;
    assign o_fix_ready = m_ready;
    assign o_res_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_lat       = r_o_lat;
    assign o_lon       = r_o_lon;

    // floor(M*5/3) by reciprocal multiply
    assign lat_prod = PROD_W'(i_fix.lat_min) * PROD_W'(MIN_RECIP);
    assign lon_prod = PROD_W'(i_fix.lon_min) * PROD_W'(MIN_RECIP);

    // Multiply stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= i_fix_valid;
        end
        if (m_ready && i_fix_valid) begin
            r_m_status    <= i_fix.status;
            r_m_lat_whole <= LAT_W'(i_fix.lat_deg) * LAT_W'(MICRO);
            r_m_lon_whole <= LON_W'(i_fix.lon_deg) * LON_W'(MICRO);
            r_m_lat_frac  <= lat_prod[MIN_SHIFT +: FRAC_W];
            r_m_lon_frac  <= lon_prod[MIN_SHIFT +: FRAC_W];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready) begin
            r_o_valid <= r_m_valid;
        end
        if (o_ready && r_m_valid) begin
            r_o_status <= r_m_status;
            r_o_lat    <= r_m_lat_whole + LAT_W'(r_m_lat_frac);
            r_o_lon    <= r_m_lon_whole + LON_W'(r_m_lon_frac);
        end
    end

endmodule : ngga_conv
`default_nettype wire

// ===== hw/rtl/nmea_gga_position_parser_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_gga_position_parser_unit
// Takes a received NMEA sentence one byte per transfer and returns one
// position result per sentence.
// ----------------------------------------------------------------------------
// One byte is accepted every clock cycle, but a final byte (tlast) waits while
// the snapshot register is full; it yields one result transfer via the input,
// snapshot, multiply and result registers, other bytes none. The rate is set
// by the per-byte scanner, which updates position, prefix and digit state; the
// conversion is a two-register pipeline (constant multiplies, then one add)
// with its own handshake, so other bytes keep flowing while a result waits. The
// sentence must begin with "$GNGGA,". Latitude degrees sit at bytes 18-19,
// minutes at 20-21 and 23-26; longitude degrees at 31-33, minutes at 34-35
// and 37-40 (counting from 0). The result is degrees*1000000 +
// floor(minutes*5/3) microdegrees. Status 1 flags a bad or short prefix,
// status 2 a non-digit or missing digit; coordinates are zero on any error. State clears after every final byte.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire         s_axis_tlast,   // end_of_sentence
    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [26:0] latitude_micro, [56:27] longitude_micro
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ngga_pkg::*;

    logic                fix_valid;
    logic                fix_ready;
    t_fix                fix;
    t_status             status;
    logic [LAT_W-1:0]    lat;
    logic [LON_W-1:0]    lon;

    // Byte scanner
    ngga_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .o_fix_valid  (fix_valid),
        .i_fix_ready  (fix_ready),
        .o_fix        (fix)
    );

    // Microdegree conversion
    ngga_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fix_valid (fix_valid),
        .o_fix_ready (fix_ready),
        .i_fix       (fix),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_status    (status),
        .o_lat       (lat),
        .o_lon       (lon)
    );

    // Result packing
    assign m_axis_tdata = {7'd0, lon, lat};
    assign m_axis_tuser = status;

endmodule : nmea_gga_position_parser_unit
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GGA position parser. Sentences are streamed in
// byte by byte; an in-bench scanner follows the same byte positions, builds
// the expected status and microdegree coordinates on each final byte, and
// every result transfer is compared against the oldest expected fix. A short
// table of hand-made sentences comes first, then random well-formed, cut-off,
// corrupted and noise sentences, with random idle gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import ngga_pkg::*;

    localparam int          RAND_BYTES     = 670;
    localparam int          MIN_RAND_FIXES = 14;
    localparam int          LONG_HOLD      = 600;
    localparam int          HOLD_AFTER     = 16;
    localparam int          MID_DRAIN_LINE = 12;
    localparam int          NUM_DIR        = 11;
    localparam logic [55:0] GGA_TAG        = "$GNGGA,";
    localparam logic [63:0] MICRO_PER_DEG  = 64'd1000000;

    // One expected result transfer
    typedef struct packed {
        t_status          status;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } pos_fix_t;

    // Hand-typed answer for one sentence, used when known at a glance
    typedef struct {
        bit       fixed;
        pos_fix_t fix;
    } answer_t;

    typedef struct {
        string    text;
        bit       fixed;
        pos_fix_t fix;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tlast = 1'b0;    // end_of_sentence
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [26:0] latitude_micro, [56:27] longitude_micro
    logic [1:0]  m_axis_tuser;           // [1:0] status

    // Scanner state, mirrors the block's per-sentence registers
    logic [POS_W-1:0]     scan_pos;
    logic                 tag_ok;
    logic                 digits_ok;
    logic [LAT_DEG_W-1:0] lat_deg_acc;
    logic [MIN_W-1:0]     lat_min_acc;
    logic [LON_DEG_W-1:0] lon_deg_acc;
    logic [MIN_W-1:0]     lon_min_acc;

    pos_fix_t    pending_fixes[$];
    answer_t     typed_answers[$];
    logic [7:0]  line_buf[$];
    int          mismatch_count = 0;
    int          fixes_seen = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;
    bit          hold_done = 1'b0;

    // Directed sentences; typed answers where the result is obvious
    stim_row_t dir_rows [NUM_DIR] = '{
        '{"$", 1'b1, '{ST_PREFIX, 27'd0, 30'd0}},
        '{"$GNGGA", 1'b1, '{ST_PREFIX, 27'd0, 30'd0}},
        '{"$GNGGA,", 1'b1, '{ST_DIGIT, 27'd0, 30'd0}},
        '{"$GNGGA,123519.000,9999.9999,N,099999.9999,E", 1'b1,
          '{ST_OK, 27'd100666665, 30'd1000666665}},
        '{"$GNGGA,000000.000,0000.0000,S,000000.0000,W", 1'b1,
          '{ST_OK, 27'd0, 30'd0}},
        '{"$GPGGA,123519.000,4807.0380,N,001131.0000,E", 1'b1,
          '{ST_PREFIX, 27'd0, 30'd0}},
        '{"$GNGGA,123519.000,48A7.0380,N,001131.0000,E", 1'b1,
          '{ST_DIGIT, 27'd0, 30'd0}},
        '{"$GPGGA,123519.000,48A7.0380,N,001131.0000,E", 1'b1,
          '{ST_PREFIX, 27'd0, 30'd0}},
        '{"$GNGGA,123519.000,4807.0380,N,001131.000", 1'b1,
          '{ST_DIGIT, 27'd0, 30'd0}},
        '{"$GNGGA,123519.000,4807.0380,N,001131.0000", 1'b0,
          '{ST_OK, 27'd0, 30'd0}},
        '{"$GNGGA,123519.000,4807.0380,N,001131.0000,E,1,08,0.9,545.4,M,46.9,M,,*47",
          1'b0, '{ST_OK, 27'd0, 30'd0}}
    };

    nmea_gga_position_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic clear_scan();
        scan_pos    = '0;
        tag_ok      = 1'b1;
        digits_ok   = 1'b1;
        lat_deg_acc = '0;
        lat_min_acc = '0;
        lon_deg_acc = '0;
        lon_min_acc = '0;
    endtask

    // Follow one accepted byte; on the final byte queue the expected fix
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_digit_kind      kind;
        logic [DIGIT_W-1:0] d;
        logic             is_digit;
        logic [POS_W-1:0] pos_at;
        logic [63:0]      lat_full;
        logic [63:0]      lon_full;
        pos_fix_t         fix;
        answer_t          ans;
        pos_at   = scan_pos;
        is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        d        = DIGIT_W'(b - ASCII_ZERO);
        if (scan_pos < PREFIX_LEN) begin
            if (b != GGA_TAG[8*(int'(PREFIX_LAST) - int'(scan_pos)) +: 8]) tag_ok = 1'b0;
        end
        case (scan_pos)
            6'd18, 6'd19:                                   kind = DK_LAT_DEG;
            6'd20, 6'd21, 6'd23, 6'd24, 6'd25, 6'd26:       kind = DK_LAT_MIN;
            6'd31, 6'd32, 6'd33:                            kind = DK_LON_DEG;
            6'd34, 6'd35, 6'd37, 6'd38, 6'd39, 6'd40:       kind = DK_LON_MIN;
            default:                                        kind = DK_NONE;
        endcase
        // Digits shift in decimal; a non-digit only poisons the sentence
        if (kind != DK_NONE) begin
            if (!is_digit) begin
                digits_ok = 1'b0;
            end else begin
                case (kind)
                    DK_LAT_DEG: lat_deg_acc = lat_deg_acc * 4'd10 + d;
                    DK_LAT_MIN: lat_min_acc = lat_min_acc * 4'd10 + d;
                    DK_LON_DEG: lon_deg_acc = lon_deg_acc * 4'd10 + d;
                    default:    lon_min_acc = lon_min_acc * 4'd10 + d;
                endcase
            end
        end
        if (scan_pos != POS_MAX) scan_pos = scan_pos + 1'b1;
        if (last) begin
            fix.lat = '0;
            fix.lon = '0;
            if (!tag_ok || pos_at < PREFIX_LAST) begin
                fix.status = ST_PREFIX;
            end else if (!digits_ok || pos_at < LAST_DIGIT_POS) begin
                fix.status = ST_DIGIT;
            end else begin
                fix.status = ST_OK;
                lat_full = 64'(lat_deg_acc) * MICRO_PER_DEG + (64'(lat_min_acc) * 64'd5) / 64'd3;
                lon_full = 64'(lon_deg_acc) * MICRO_PER_DEG + (64'(lon_min_acc) * 64'd5) / 64'd3;
                fix.lat  = lat_full[LAT_W-1:0];
                fix.lon  = lon_full[LON_W-1:0];
            end
            if (typed_answers.size() != 0) begin
                ans = typed_answers.pop_front();
                if (ans.fixed) fix = ans.fix;
            end
            pending_fixes.push_back(fix);
            clear_scan();
        end
    endtask

    // Compare one result transfer with the oldest expected fix
    task automatic check_fix();
        pos_fix_t want;
        fixes_seen++;
        if (pending_fixes.size() == 0) begin
            $error("result transfer with no sentence pending: status=%0d", m_axis_tuser);
            mismatch_count++;
        end else begin
            want = pending_fixes.pop_front();
            if (m_axis_tuser !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                mismatch_count++;
            end
            if (m_axis_tdata[26:0] !== want.lat) begin
                $error("latitude_micro: expected %0d, got %0d", want.lat, m_axis_tdata[26:0]);
                mismatch_count++;
            end
            if (m_axis_tdata[56:27] !== want.lon) begin
                $error("longitude_micro: expected %0d, got %0d", want.lon, m_axis_tdata[56:27]);
                mismatch_count++;
            end
        end
    endtask

    // Monitor both streams on every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) check_fix();
        end
    end

    // Byte transfer; valid stays high when no gap follows
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_line(input bit fixed, input pos_fix_t fix);
        answer_t ans;
        int      i;
        ans.fixed = fixed;
        ans.fix   = fix;
        typed_answers.push_back(ans);
        quiet_tx = ($urandom_range(0, 3) == 0);
        for (i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    // Sender stops until every expected fix has come back
    task automatic drain_fixes();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_fixes.size() != 0);
    endtask

    // Plausible character for a position of a well-formed sentence
    function automatic logic [7:0] gga_char(input int p);
        if (p < 7) return GGA_TAG[8*(6 - p) +: 8];
        if (p == 22 || p == 36) return ".";
        if ((p >= 18 && p <= 26) || (p >= 31 && p <= 40))
            return 8'(ASCII_ZERO + $urandom_range(0, 9));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Mostly well-formed sentences, plus cut-off, corrupted and noise lines
    task automatic make_random_line();
        int sel;
        int len;
        int i;
        int hit;
        line_buf.delete();
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            len = $urandom_range(1, 70);
            for (i = 0; i < len; i++) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (sel < 30) len = $urandom_range(1, 40);
            else if ($urandom_range(0, 7) == 0) len = $urandom_range(41, 80);
            else len = $urandom_range(41, 48);
            for (i = 0; i < len; i++) line_buf.push_back(gga_char(i));
            if (sel >= 88) begin
                hit = $urandom_range(0, (len > 41) ? 40 : len - 1);
                line_buf[hit] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    // Result side: random stalls, quiet stretches, one long hold-off
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && fixes_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
            stall = pick_gap(quiet_rx);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int r;
        int i;
        int rand_bytes;
        int rand_lines;
        clear_scan();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_DIR; r++) begin
            line_buf.delete();
            for (i = 0; i < dir_rows[r].text.len(); i++) line_buf.push_back(dir_rows[r].text[i]);
            send_line(dir_rows[r].fixed, dir_rows[r].fix);
        end
        drain_fixes();

        rand_bytes = 0;
        rand_lines = 0;
        while (rand_bytes < RAND_BYTES || rand_lines < MIN_RAND_FIXES) begin
            make_random_line();
            rand_bytes += line_buf.size();
            send_line(1'b0, '{ST_OK, 27'd0, 30'd0});
            rand_lines++;
            if (rand_lines == MID_DRAIN_LINE) drain_fixes();
        end
        drain_fixes();
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ngga_pkg.sv
hw/rtl/ngga_scan.sv
hw/rtl/ngga_conv.sv
hw/rtl/nmea_gga_position_parser_unit.sv
dv/tb_top.sv
